[design/scds_pkg.sv]
// Shared types, constants and helpers for the sample clock divisor select block.
package scds_pkg;

    localparam int REQ_W      = 32;
    localparam int BASE_W     = 29;
    localparam int DIV_W      = 8;
    localparam int ENC_W      = 17;
    localparam int MHZ_W      = 39;
    localparam int PROD_W     = 42;
    localparam int DE_W       = 17;
    localparam int NUM_DE_W   = 33;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int IN_TDATA_W = 32;
    localparam int OUT_TDATA_W = 64;

    localparam logic [BASE_W-1:0] CORE_CLK_RST = 29'd48000000;
    localparam logic [DIV_W-1:0]  DIVIDER_RST  = 8'd1;
    localparam logic [REQ_W-1:0]  MAX_RATE_RST = 32'd12000000;

    localparam logic [CFG_IDX_W-1:0] CFG_CORE_CLK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIVIDER  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RATE = 2'd2;

    // Divisor choice
    localparam logic [1:0] SEL_FULL    = 2'd0;
    localparam logic [1:0] SEL_TWO3    = 2'd1;
    localparam logic [1:0] SEL_HALF    = 2'd2;
    localparam logic [1:0] SEL_EIGHTHS = 2'd3;

    // floor(x / 3) = (x * RECIP3) >> RECIP3_SHIFT for any x below 2^32
    localparam logic [31:0] RECIP3       = 32'hAAAAAAAB;
    localparam int          RECIP3_SHIFT = 33;

    localparam logic [9:0]      MILLI    = 10'd1000;
    localparam logic [12:0]     MILLI8   = 13'd8000;
    localparam logic [DE_W-1:0] DE_MAX   = 17'h1ffff;

    typedef struct packed {
        logic [REQ_W-1:0] req_orig;
        logic [REQ_W-1:0] req;
    } d1_side_t;

    typedef struct packed {
        logic [REQ_W-1:0]  req_orig;
        logic [1:0]        sel;
        logic [BASE_W-1:0] spec;
        logic [BASE_W-1:0] bb;
        logic              ovf;
    } d2_side_t;

    typedef struct packed {
        logic [REQ_W-1:0]  req_orig;
        logic [1:0]        sel;
        logic [BASE_W-1:0] spec;
        logic [ENC_W-1:0]  enc;
    } d3_side_t;

    function automatic logic [2:0] frac_code(input logic [2:0] frac);
        logic [2:0] code;
        case (frac)
            3'd0:    code = 3'd0;
            3'd1:    code = 3'd3;
            3'd2:    code = 3'd2;
            3'd3:    code = 3'd4;
            3'd4:    code = 3'd1;
            3'd5:    code = 3'd5;
            3'd6:    code = 3'd6;
            default: code = 3'd7;
        endcase
        return code;
    endfunction

endpackage

[design/scds_pipe_div.sv]
// Pipelined restoring divider: one quotient bit per register stage, side data alongside.
module scds_pipe_div #(
    parameter int NUM_W  = 32,
    parameter int DEN_W  = 32,
    parameter int QUO_W  = 32,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [QUO_W-1:0]  quo,
    output logic [SIDE_W-1:0] side_out
);

    // The quotient must fit in QUO_W bits: num < den << QUO_W.
    localparam int W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

    logic              valid_reg [QUO_W];
    logic [W-1:0]      rem_reg   [QUO_W];
    logic [DEN_W-1:0]  den_reg   [QUO_W];
    logic [QUO_W-1:0]  quo_reg   [QUO_W];
    logic [SIDE_W-1:0] side_reg  [QUO_W];

    for (genvar s = 0; s < QUO_W; s++) begin : g_stage
        localparam int K = QUO_W - 1 - s;

        logic              valid_in;
        logic [W-1:0]      rem_in;
        logic [DEN_W-1:0]  den_in;
        logic [QUO_W-1:0]  quo_in;
        logic [SIDE_W-1:0] side_d;
        logic [W-1:0]      trial;
        logic              take;

        if (s == 0) begin : g_first
            always_comb
            begin
                valid_in = in_valid;
                rem_in   = W'(num);
                den_in   = den;
                quo_in   = '0;
                side_d   = side_in;
            end
        end else begin : g_next
            always_comb
            begin
                valid_in = valid_reg[s-1];
                rem_in   = rem_reg[s-1];
                den_in   = den_reg[s-1];
                quo_in   = quo_reg[s-1];
                side_d   = side_reg[s-1];
            end
        end

        assign trial = W'(den_in) << K;
        assign take  = (rem_in >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[s] <= 1'b0;
            else if (en)
                valid_reg[s] <= valid_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s]  <= take ? (rem_in - trial) : rem_in;
                den_reg[s]  <= den_in;
                quo_reg[s]  <= quo_in | (QUO_W'(take) << K);
                side_reg[s] <= side_d;
            end
        end
    end

    assign out_valid = valid_reg[QUO_W-1];
    assign quo       = quo_reg[QUO_W-1];
    assign side_out  = side_reg[QUO_W-1];

endmodule

[design/sample_clock_divisor_select.sv]
// Top level: sample clock divisor select, fully pipelined.
//
//  Channel   Direction  Signals                            Transfer carries
//  ------    ---------  ---------------------------------  ---------------------------
//  s_*       in         s_tvalid s_tready s_tdata[31:0]    wanted sample rate
//  m_*       out        m_tvalid m_tready m_tdata[63:0]    divisor, rate, exact flag
//  cfg_*     in         cfg_valid cfg_ready cfg_index/data register write, always ready
//
//  One request enters per cycle unless the pipe is stalled; the pipe is made of
//  the three bit-per-stage dividers (bitbang clock 29, eighths divisor 17, achieved rate
//  39 stages) plus six arithmetic and output stages.
//  Reset clears all valid bits and loads the register defaults (48 MHz, divider 1,
//  12 MHz maximum). A held result at the output stalls the pipe only when the last
//  stage holds an item; until then the whole pipe advances and input keeps being taken.
module sample_clock_divisor_select
    import scds_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [31:0] wanted rate, Hz
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [16:0] divisor code, [55:17] rate in mHz,
                                              // [56] exact, [63:57] zero
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // Configuration registers
    logic [BASE_W-1:0] core_clk_reg;
    logic [DIV_W-1:0]  bitbang_divider_reg;
    logic [REQ_W-1:0]  max_rate_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            core_clk_reg        <= CORE_CLK_RST;
            bitbang_divider_reg <= DIVIDER_RST;
            max_rate_reg        <= MAX_RATE_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_CORE_CLK:   core_clk_reg        <= cfg_data[BASE_W-1:0];
                CFG_DIVIDER:    bitbang_divider_reg <= cfg_data[DIV_W-1:0];
                CFG_MAX_RATE:   max_rate_reg        <= cfg_data[REQ_W-1:0];
                default:        ;
            endcase
        end
    end

    // Pipe advance: hold only when the output is full, not taken, and the last stage is busy
    logic en;
    logic p4_valid_reg;
    logic out_valid_reg;

    assign en       = m_tready || !out_valid_reg || !p4_valid_reg;
    assign s_tready = en;

    // Entry stage: clamp the request
    logic             e_valid_reg;
    logic [REQ_W-1:0] e_req_orig_reg;
    logic [REQ_W-1:0] e_req_reg;
    logic [REQ_W-1:0] req_clamp;
    logic [REQ_W-1:0] req_next;

    assign req_clamp = (s_tdata > max_rate_reg) ? max_rate_reg : s_tdata;
    assign req_next  = (req_clamp == '0) ? REQ_W'(1) : req_clamp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e_valid_reg <= 1'b0;
        else if (en)
            e_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_req_orig_reg <= s_tdata;
            e_req_reg      <= req_next;
        end
    end

    // Bitbang clock = core clock / divider
    logic [DIV_W-1:0]  div_eff;
    d1_side_t          d1_side_in;
    d1_side_t          d1_side_out;
    logic              d1_valid;
    logic [BASE_W-1:0] d1_bb;

    assign div_eff = (bitbang_divider_reg == '0) ? DIV_W'(1) : bitbang_divider_reg;
    assign d1_side_in.req_orig = e_req_orig_reg;
    assign d1_side_in.req      = e_req_reg;

    scds_pipe_div #(
        .NUM_W  (BASE_W),
        .DEN_W  (DIV_W),
        .QUO_W  (BASE_W),
        .SIDE_W ($bits(d1_side_t))
    ) u_div_bb (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (e_valid_reg),
        .num       (core_clk_reg),
        .den       (div_eff),
        .side_in   (d1_side_in),
        .out_valid (d1_valid),
        .quo       (d1_bb),
        .side_out  (d1_side_out)
    );

    // P1: two-thirds clock by reciprocal multiply
    logic              p1_valid_reg;
    logic [BASE_W-1:0] p1_bb_reg;
    logic [BASE_W-1:0] p1_two3_reg;
    logic [REQ_W-1:0]  p1_req_orig_reg;
    logic [REQ_W-1:0]  p1_req_reg;
    logic [61:0]       two3_prod;

    assign two3_prod = 62'({d1_bb, 1'b0}) * 62'(RECIP3);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p1_valid_reg <= 1'b0;
        else if (en)
            p1_valid_reg <= d1_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_bb_reg       <= d1_bb;
            p1_two3_reg     <= two3_prod[RECIP3_SHIFT +: BASE_W];
            p1_req_orig_reg <= d1_side_out.req_orig;
            p1_req_reg      <= d1_side_out.req;
        end
    end

    // P2: midpoint compares, rounding numerator and overflow check
    logic [BASE_W-1:0]   half;
    logic [BASE_W:0]     sum_full;
    logic [BASE_W:0]     sum_two3;
    logic [REQ_W-1:0]    thr_full;
    logic [REQ_W-1:0]    thr_two3;
    logic [1:0]          sel_next;
    logic [BASE_W-1:0]   spec_next;
    logic [NUM_DE_W-1:0] num_de;
    logic                ovf_next;

    assign half     = p1_bb_reg >> 1;
    assign sum_full = (BASE_W+1)'(p1_bb_reg) + (BASE_W+1)'(p1_two3_reg);
    assign sum_two3 = (BASE_W+1)'(p1_two3_reg) + (BASE_W+1)'(half);
    assign thr_full = REQ_W'(sum_full[BASE_W:1]);
    assign thr_two3 = REQ_W'(sum_two3[BASE_W:1]);
    assign num_de   = NUM_DE_W'({p1_bb_reg, 3'b000}) + NUM_DE_W'(p1_req_reg >> 1);
    // Eighths quotient would exceed 17 bits
    assign ovf_next = ((REQ_W+DE_W)'(num_de) >= {p1_req_reg, {DE_W{1'b0}}});

    always_comb
    begin
        if (p1_req_reg > thr_full)
        begin
            sel_next  = SEL_FULL;
            spec_next = p1_bb_reg;
        end
        else if (p1_req_reg > thr_two3)
        begin
            sel_next  = SEL_TWO3;
            spec_next = p1_two3_reg;
        end
        else if (p1_req_reg > REQ_W'(half))
        begin
            sel_next  = SEL_HALF;
            spec_next = half;
        end
        else
        begin
            sel_next  = SEL_EIGHTHS;
            spec_next = half;
        end
    end

    logic                p2_valid_reg;
    logic [REQ_W-1:0]    p2_req_reg;
    logic [NUM_DE_W-1:0] p2_num_reg;
    d2_side_t            p2_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p2_valid_reg <= 1'b0;
        else if (en)
            p2_valid_reg <= p1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p2_req_reg           <= p1_req_reg;
            p2_num_reg           <= num_de;
            p2_side_reg.req_orig <= p1_req_orig_reg;
            p2_side_reg.sel      <= sel_next;
            p2_side_reg.spec     <= spec_next;
            p2_side_reg.bb       <= p1_bb_reg;
            p2_side_reg.ovf      <= ovf_next;
        end
    end

    // Divisor in eighths, rounded
    logic            d2_valid;
    logic [DE_W-1:0] d2_quo;
    d2_side_t        d2_side_out;

    scds_pipe_div #(
        .NUM_W  (NUM_DE_W),
        .DEN_W  (REQ_W),
        .QUO_W  (DE_W),
        .SIDE_W ($bits(d2_side_t))
    ) u_div_de (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (p2_valid_reg),
        .num       (p2_num_reg),
        .den       (p2_req_reg),
        .side_in   (p2_side_reg),
        .out_valid (d2_valid),
        .quo       (d2_quo),
        .side_out  (d2_side_out)
    );

    // P3: clamp, encode, scale the clock for the rate division
    logic [DE_W-1:0]   de_sat;
    logic [DE_W-1:0]   de_next;
    logic [ENC_W-1:0]  enc_next;
    logic [PROD_W-1:0] num_rate;

    assign de_sat   = d2_side_out.ovf ? DE_MAX : d2_quo;
    assign de_next  = (de_sat == '0) ? DE_W'(1) : de_sat;
    assign enc_next = {frac_code(de_next[2:0]), de_next[DE_W-1:3]};
    assign num_rate = PROD_W'(d2_side_out.bb) * PROD_W'(MILLI8);

    logic              p3_valid_reg;
    logic [DE_W-1:0]   p3_de_reg;
    logic [PROD_W-1:0] p3_num_reg;
    d3_side_t          p3_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p3_valid_reg <= 1'b0;
        else if (en)
            p3_valid_reg <= d2_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p3_de_reg            <= de_next;
            p3_num_reg           <= num_rate;
            p3_side_reg.req_orig <= d2_side_out.req_orig;
            p3_side_reg.sel      <= d2_side_out.sel;
            p3_side_reg.spec     <= d2_side_out.spec;
            p3_side_reg.enc      <= enc_next;
        end
    end

    // Achieved rate = clock * 8000 / eighths; on the eighths path the divisor is at least
    // sixteen, so the quotient fits in the rate field
    logic             d3_valid;
    logic [MHZ_W-1:0] d3_quo;
    d3_side_t         d3_side_out;

    scds_pipe_div #(
        .NUM_W  (PROD_W),
        .DEN_W  (DE_W),
        .QUO_W  (MHZ_W),
        .SIDE_W ($bits(d3_side_t))
    ) u_div_rate (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (p3_valid_reg),
        .num       (p3_num_reg),
        .den       (p3_de_reg),
        .side_in   (p3_side_reg),
        .out_valid (d3_valid),
        .quo       (d3_quo),
        .side_out  (d3_side_out)
    );

    // P4: pick special or divided result, form the exact-match reference
    logic [MHZ_W-1:0]  p4_mhz_reg;
    logic [ENC_W-1:0]  p4_enc_reg;
    logic [PROD_W-1:0] p4_prod_reg;
    logic [MHZ_W-1:0]  spec_mhz;
    logic              eighths;

    assign spec_mhz = MHZ_W'(MHZ_W'(d3_side_out.spec) * MHZ_W'(MILLI));
    assign eighths  = (d3_side_out.sel == SEL_EIGHTHS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p4_valid_reg <= 1'b0;
        else if (en)
            p4_valid_reg <= d3_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p4_mhz_reg  <= eighths ? d3_quo : spec_mhz;
            p4_enc_reg  <= eighths ? d3_side_out.enc : ENC_W'(d3_side_out.sel);
            p4_prod_reg <= PROD_W'(d3_side_out.req_orig) * PROD_W'(MILLI);
        end
    end

    // Output register
    logic [ENC_W-1:0] out_enc_reg;
    logic [MHZ_W-1:0] out_mhz_reg;
    logic             out_exact_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en && p4_valid_reg)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (en && p4_valid_reg)
        begin
            out_enc_reg   <= p4_enc_reg;
            out_mhz_reg   <= p4_mhz_reg;
            out_exact_reg <= (p4_prod_reg == PROD_W'(p4_mhz_reg));
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'({out_exact_reg, out_mhz_reg, out_enc_reg});

endmodule
